>>> hw/rtl/weighted_histogram_binner_assert.svh
// Assertion macros used by the checker module of the histogram binner.
// Both sample on the rising edge of aclk and are off while aresetn is low.
`ifndef WEIGHTED_HISTOGRAM_BINNER_ASSERT_SVH
`define WEIGHTED_HISTOGRAM_BINNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WHB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WHB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/whb_pkg.sv
`default_nettype none

package whb_pkg;

    // Width of the floored cell number taken from the product.
    localparam int CELL_W     = 18;
    // Width of the signed product of the 17-bit difference and the scale.
    localparam int PROD_W     = 42;
    // Address field wide enough for the largest bin store.
    localparam int ADDR_MAX_W = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        CFG_LOWER_BOUND = 3'd0,
        CFG_CELL_SCALE  = 3'd1,
        CFG_NUM_CELLS   = 3'd2,
        CFG_TRUNCATE    = 3'd3,
        CFG_USE_WEIGHT  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_ACC        = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_EMPTY = 2'd2
    } op_t;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] sample;
        logic [15:0]        weight;
        logic [6:0]         bin_index;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  bin_number;
        logic [31:0] bin_total;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] lower_bound;
        logic [23:0]        cell_scale;
        logic [7:0]         num_cells;
        logic               truncate;
        logic               use_weight;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic [ADDR_MAX_W-1:0] addr;
        logic [15:0]           inc;
        logic [6:0]            bin_number;
    } op_entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/whb_front.sv
`default_nettype none

module whb_front #(
    parameter int NUM_BINS = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire whb_pkg::in_item_t    s_data,
    input  wire whb_pkg::cfg_t        cfg,
    input  wire logic                 clearing,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output whb_pkg::op_entry_t        push_data
);

    localparam int CW = $clog2(NUM_BINS + 1);

    logic                                  p1_valid_reg;
    logic                                  p1_valid_next;
    logic                                  p1_cmd_reg;
    logic signed [whb_pkg::PROD_W-1:0]     p1_prod_reg;
    logic signed [whb_pkg::PROD_W-1:0]     prod_next;
    logic [15:0]                           p1_inc_reg;
    logic [15:0]                           inc_next;
    logic [6:0]                            p1_bin_reg;

    logic signed [16:0]                    diff;
    logic signed [24:0]                    scale_s;
    logic signed [whb_pkg::CELL_W-1:0]     cell_num;
    logic [whb_pkg::CELL_W-2:0]            cell_mag;
    logic [CW-1:0]                         ncl;
    logic                                  cell_hi;
    logic                                  keep;
    logic                                  accept;
    logic                                  p1_done;

    assign diff      = $signed({s_data.sample[15], s_data.sample})
                     - $signed({cfg.lower_bound[15], cfg.lower_bound});
    assign scale_s   = $signed({1'b0, cfg.cell_scale});
    assign prod_next = diff * scale_s;
    assign inc_next  = cfg.use_weight ? s_data.weight : 16'd1;

    // The arithmetic shift of the exact product floors toward minus infinity.
    assign cell_num = p1_prod_reg[whb_pkg::PROD_W-1:whb_pkg::PROD_W-whb_pkg::CELL_W];
    assign cell_mag = cell_num[whb_pkg::CELL_W-2:0];
    assign ncl      = (32'(cfg.num_cells) > 32'(NUM_BINS)) ? CW'(NUM_BINS)
                                                          : CW'(cfg.num_cells);
    assign cell_hi  = 32'(cell_mag) >= 32'(ncl);

    always_comb begin
        keep                 = 1'b1;
        push_data.op         = whb_pkg::OP_ACC;
        push_data.addr       = whb_pkg::ADDR_MAX_W'(cell_mag);
        push_data.inc        = p1_inc_reg;
        push_data.bin_number = p1_bin_reg;
        if (p1_cmd_reg) begin
            push_data.addr = whb_pkg::ADDR_MAX_W'(p1_bin_reg);
            if (32'(p1_bin_reg) < 32'(NUM_BINS)) begin
                push_data.op = whb_pkg::OP_READ;
            end else begin
                push_data.op = whb_pkg::OP_READ_EMPTY;
            end
        end else if (ncl == '0) begin
            keep = 1'b0;
        end else if (cell_num[whb_pkg::CELL_W-1]) begin
            keep           = cfg.truncate;
            push_data.addr = '0;
        end else if (cell_hi) begin
            keep           = cfg.truncate;
            push_data.addr = whb_pkg::ADDR_MAX_W'(ncl - CW'(1));
        end
    end

    assign push_valid    = p1_valid_reg && keep;
    assign p1_done       = p1_valid_reg && (!keep || push_ready);
    assign s_ready       = (!p1_valid_reg || p1_done) && !clearing;
    assign accept        = s_valid && s_ready;
    assign p1_valid_next = accept ? 1'b1 : (p1_done ? 1'b0 : p1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_cmd_reg  <= s_data.cmd;
            p1_prod_reg <= prod_next;
            p1_inc_reg  <= inc_next;
            p1_bin_reg  <= s_data.bin_index;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/whb_queue.sv
`default_nettype none

module whb_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire whb_pkg::op_entry_t  push_data,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output whb_pkg::op_entry_t       pop_data
);

    whb_pkg::op_entry_t              entry_reg [whb_pkg::QUEUE_DEPTH];
    logic [whb_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [whb_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [whb_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [whb_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [whb_pkg::QPTR_W:0]        count_reg;
    logic [whb_pkg::QPTR_W:0]        count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = count_reg != (whb_pkg::QPTR_W + 1)'(whb_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + (whb_pkg::QPTR_W + 1)'(do_push)
                       - (whb_pkg::QPTR_W + 1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/whb_back.sv
`default_nettype none

module whb_back #(
    parameter int NUM_BINS = 128
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire whb_pkg::op_entry_t  pop_data,
    output logic                     clearing,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output whb_pkg::out_item_t       m_data
);

    localparam int AW = $clog2(NUM_BINS);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    logic [31:0]              mem [NUM_BINS];
    logic [31:0]              rdata_reg;

    state_t                   state_reg;
    state_t                   state_next;
    logic [AW-1:0]            clr_cnt_reg;
    logic [AW-1:0]            clr_cnt_next;
    whb_pkg::op_entry_t       op_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    whb_pkg::out_item_t       out_reg;
    whb_pkg::out_item_t       out_next;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [31:0]              mem_wdata;
    logic                     mem_re;
    logic [32:0]              sum;
    logic                     out_free;

    assign sum      = {1'b0, rdata_reg} + 33'(op_reg.inc);
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pop_ready      = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = op_reg.addr[AW-1:0];
        mem_wdata      = '0;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(NUM_BINS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    mem_re     = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                case (op_reg.op)
                    whb_pkg::OP_ACC: begin
                        mem_we     = 1'b1;
                        mem_wdata  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        state_next = ST_IDLE;
                    end
                    whb_pkg::OP_READ, whb_pkg::OP_READ_EMPTY: begin
                        if (out_free) begin
                            mem_we              = op_reg.op == whb_pkg::OP_READ;
                            out_valid_next      = 1'b1;
                            out_next.bin_number = op_reg.bin_number;
                            out_next.bin_total  = (op_reg.op == whb_pkg::OP_READ)
                                                ? rdata_reg : 32'd0;
                            state_next          = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (pop_valid && pop_ready) begin
            op_reg <= pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[pop_data.addr[AW-1:0]];
        end
    end

    assign clearing = state_reg == ST_CLEAR;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/weighted_histogram_binner.sv
// Weighted histogram binner.
// Input items arrive on s_valid/s_ready/s_data. An accumulate item (cmd 0)
// maps its signed Q8.8 sample to cell floor((sample - lower_bound) *
// cell_scale / 2^24) and adds its weight, or one when weighting is off, to
// that cell's 32-bit total, saturating. Samples outside the cells in use are
// dropped, or clamped to the end cells when truncate is set. A read item
// (cmd 1) returns one bin's total on m_valid/m_ready/m_data and clears it.
// Configuration registers are written on cfg_valid/cfg_index/cfg_data; the
// user must write them only while the block is idle; the block does not
// enforce this. cfg_ready is always high. The front stage takes one item a
// cycle while the queue has room. The back end reads a bin in its idle state
// and writes it in its update state, and takes no new item in between;
// dropped samples pass the front stage at one a cycle. A read result passes
// the front-stage, queue, operand and output registers. A four-entry queue
// separates the front from the back end, so a stalled receiver only stops
// intake once it fills. After reset the bin store is zeroed, during which
// s_ready stays low; registers return to their defaults at once.
`default_nettype none

module weighted_histogram_binner #(
    parameter int NUM_BINS = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire whb_pkg::in_item_t    s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output whb_pkg::out_item_t        m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [23:0]          cfg_data
);

    whb_pkg::cfg_t       cfg_reg;
    whb_pkg::cfg_t       cfg_next;
    logic                clearing;
    logic                push_valid;
    logic                push_ready;
    whb_pkg::op_entry_t  push_data;
    logic                pop_valid;
    logic                pop_ready;
    whb_pkg::op_entry_t  pop_data;

    assign cfg_ready = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                whb_pkg::CFG_LOWER_BOUND: cfg_next.lower_bound = $signed(cfg_data[15:0]);
                whb_pkg::CFG_CELL_SCALE:  cfg_next.cell_scale  = cfg_data;
                whb_pkg::CFG_NUM_CELLS:   cfg_next.num_cells   = cfg_data[7:0];
                whb_pkg::CFG_TRUNCATE:    cfg_next.truncate    = cfg_data[0];
                whb_pkg::CFG_USE_WEIGHT:  cfg_next.use_weight  = cfg_data[0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_bound <= 16'sd0;
            cfg_reg.cell_scale  <= 24'd65536;
            cfg_reg.num_cells   <= 8'd100;
            cfg_reg.truncate    <= 1'b0;
            cfg_reg.use_weight  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end classifies each item and drops samples that miss.
    whb_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg        (cfg_reg),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    whb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back end owns the bin store and does one operation at a time,
    // so repeated cells need no forwarding.
    whb_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/whb_checker.sv
`default_nettype none

`include "weighted_histogram_binner_assert.svh"

module whb_checker #(
    parameter int NUM_BINS = 128
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire whb_pkg::in_item_t   s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire whb_pkg::out_item_t  m_data,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready,
    input wire logic [2:0]          cfg_index,
    input wire logic [23:0]         cfg_data
);

    logic unused_ok;

    assign unused_ok = s_valid ^ ^s_data ^ cfg_valid ^ ^cfg_index ^ ^cfg_data;

    // A result that is not taken stays put.
    `WHB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // A result only goes away once it was taken.
    `WHB_ASSERT_SAME(a_out_drop, $fell(m_valid) && $past(aresetn), $past(m_ready), "result lost")

    // Bins beyond the store always read as empty.
    `WHB_ASSERT_SAME(a_out_range, m_valid && (32'(m_data.bin_number) >= 32'(NUM_BINS)), m_data.bin_total == 32'd0, "bin beyond store is not empty")

    // The store is being cleared right after reset, so no item is taken.
    `WHB_ASSERT_SAME(a_clear_pass, !$past(aresetn), !s_ready && cfg_ready, "item taken during clearing pass")

endmodule

bind weighted_histogram_binner whb_checker #(.NUM_BINS(NUM_BINS)) u_whb_checker (.*);

`default_nettype wire

>>> tb/weighted_histogram_binner_checker.sv
module weighted_histogram_binner_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  whb_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  whb_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output int                 error_count,
    output int                 reads_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import whb_pkg::*;

    localparam int STORE_DEPTH = 128;

    cfg_t        regs;
    logic [31:0] totals [STORE_DEPTH];
    out_item_t   reads_due [$];

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Floor of (sample - lower_bound) * cell_scale / 2^24, exact in 64 bits.
    function automatic int cell_of(input logic signed [15:0] sample);
        longint diff;
        longint scaled;
        diff   = longint'(sample) - longint'($signed(regs.lower_bound));
        scaled = diff * longint'(regs.cell_scale);
        return int'(scaled >>> 24);
    endfunction

    task automatic apply_item(input in_item_t it);
        int          in_use;
        int          slot;
        logic [31:0] inc;
        logic [32:0] sum;
        if (it.cmd == 1'(OP_READ)) begin
            reads_due.push_back(out_item_t'{bin_number: it.bin_index,
                                            bin_total: totals[it.bin_index]});
            totals[it.bin_index] = '0;
            return;
        end
        in_use = (regs.num_cells > STORE_DEPTH) ? STORE_DEPTH : int'(regs.num_cells);
        if (in_use == 0) return;
        slot = cell_of(it.sample);
        if (regs.truncate) begin
            if (slot < 0) slot = 0;
            if (slot >= in_use) slot = in_use - 1;
        end
        if (slot < 0 || slot >= in_use) return;
        inc = regs.use_weight ? 32'(it.weight) : 32'd1;
        sum = {1'b0, totals[slot]} + {1'b0, inc};
        totals[slot] = sum[32] ? '1 : sum[31:0];
    endtask

    task automatic apply_write(input logic [2:0] index, input logic [23:0] value);
        case (cfg_index_t'(index))
            CFG_LOWER_BOUND: regs.lower_bound = value[15:0];
            CFG_CELL_SCALE:  regs.cell_scale  = value;
            CFG_NUM_CELLS:   regs.num_cells   = value[7:0];
            CFG_TRUNCATE:    regs.truncate    = value[0];
            CFG_USE_WEIGHT:  regs.use_weight  = value[0];
            default: ;
        endcase
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (reads_due.size() == 0) begin
            report($sformatf("result for bin %0d arrived with none expected",
                             got.bin_number));
            return;
        end
        want = reads_due.pop_front();
        if (got.bin_number !== want.bin_number)
            report($sformatf("bin_number expected %0d, got %0d",
                             want.bin_number, got.bin_number));
        if (got.bin_total !== want.bin_total)
            report($sformatf("bin_total of bin %0d expected 0x%08h, got 0x%08h",
                             want.bin_number, want.bin_total, got.bin_total));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs = cfg_t'{lower_bound: 16'sd0, cell_scale: 24'd65536, num_cells: 8'd100,
                          truncate: 1'b0, use_weight: 1'b0};
            foreach (totals[i]) totals[i] = '0;
            reads_due.delete();
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (s_valid && s_ready) apply_item(s_data);
        end
        reads_pending <= reads_due.size();
    end

endmodule

>>> tb/tb_weighted_histogram_binner.sv
module tb_weighted_histogram_binner;
    timeunit 1ns;
    timeprecision 1ps;
    import whb_pkg::*;

    localparam int CLK_PERIOD_NS   = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int STORE_DEPTH     = 128;
    // An accumulate item leaves no trace on the outputs, so before a register
    // write we give the four-entry queue and the back end time to
    // empty out after the last read result.
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int PRESSURE_READS  = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } ready_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    int error_count;
    int reads_pending;
    int hold_requests = 0;
    int cycle_count   = 0;
    int burst_left    = 0;

    // The stimulus keeps its own view of the current setting so that it can
    // aim samples at cells that are in use.
    logic signed [15:0] cur_lower_bound = 16'sd0;
    logic [23:0]        cur_cell_scale  = 24'd65536;
    logic [7:0]         cur_num_cells   = 8'd100;
    logic [15:0]        last_sample     = '0;

    initial begin
        forever #(CLK_PERIOD_NS / 2) aclk = ~aclk;
    end

    weighted_histogram_binner #(
        .NUM_BINS(STORE_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    weighted_histogram_binner_checker histogram_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .reads_pending (reads_pending)
    );

    // Watchdog. A correct run takes a small fraction of this, the long
    // receiver hold-off included.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_weighted_histogram_binner: done, errors");
            $finish;
        end
    end

    // Result side. The receiver switches between always ready, a coin flip
    // per cycle and mostly stalled, each for a random stretch. When the
    // stimulus asks for it, it holds m_ready low for a long stretch so that
    // the result path backs up into the input queue.
    initial begin
        int          holds_served;
        ready_mode_t mode;
        int          mode_left;
        holds_served = 0;
        mode         = READY_ALWAYS;
        mode_left    = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = ready_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_COIN:   m_ready <= 1'($urandom);
                    default:      m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one item and returns at the edge where it is taken. Valid is
    // left high so that a following item goes out without a gap.
    task automatic push_item(input in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Sends in bursts of random length; a quarter of the gaps between bursts
    // are zero, which gives long stretches of back-to-back items.
    task automatic send_paced(input in_item_t it);
        if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
        end
        push_item(it);
        burst_left--;
    endtask

    // Waits until every read has reported and the accumulates behind it have
    // had time to retire, so that a register write cannot overtake them.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reads_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t index, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic signed [15:0] lower_bound,
                             input logic [23:0] cell_scale, input logic [7:0] num_cells,
                             input logic truncate, input logic use_weight);
        write_reg(CFG_LOWER_BOUND, {8'd0, lower_bound});
        write_reg(CFG_CELL_SCALE, cell_scale);
        write_reg(CFG_NUM_CELLS, {16'd0, num_cells});
        write_reg(CFG_TRUNCATE, {23'd0, truncate});
        write_reg(CFG_USE_WEIGHT, {23'd0, use_weight});
        cfg_valid       <= 1'b0;
        cur_lower_bound = lower_bound;
        cur_cell_scale  = cell_scale;
        cur_num_cells   = num_cells;
    endtask

    // Fields that an item does not use still carry random values.
    function automatic in_item_t acc_item(input logic [15:0] sample, input logic [15:0] weight);
        in_item_t it;
        it.cmd       = 1'(OP_ACC);
        it.sample    = sample;
        it.weight    = weight;
        it.bin_index = 7'($urandom);
        return it;
    endfunction

    function automatic in_item_t read_item(input logic [6:0] index);
        in_item_t it;
        it.cmd       = 1'(OP_READ);
        it.sample    = 16'($urandom);
        it.weight    = 16'($urandom);
        it.bin_index = index;
        return it;
    endfunction

    // Picks a cell from one below the first to one past the last in use and
    // returns a sample somewhere inside it, so that edges and clamping get
    // exercised as often as the interior.
    function automatic logic [15:0] aimed_sample();
        int     in_use;
        int     target;
        longint offset;
        if (cur_cell_scale == 0) return 16'($urandom);
        in_use = (cur_num_cells > STORE_DEPTH) ? STORE_DEPTH : int'(cur_num_cells);
        target = int'($urandom_range(0, in_use + 1)) - 1;
        offset = ((longint'(target) <<< 24) + longint'($urandom_range(0, 24'hFFFFFF)))
                 / longint'(cur_cell_scale);
        return 16'(longint'(cur_lower_bound) + offset);
    endfunction

    // A quarter reads, the rest accumulates. A quarter of the accumulates
    // reuse the previous sample so the same bin is hit on consecutive items,
    // which is where back-to-back read-modify-writes of one bin can go wrong.
    function automatic in_item_t random_item();
        int          pick;
        int          in_use;
        logic [15:0] sample;
        logic [15:0] weight;
        in_use = (cur_num_cells > STORE_DEPTH) ? STORE_DEPTH : int'(cur_num_cells);
        if ($urandom_range(0, 99) < 25) begin
            if (in_use > 0 && $urandom_range(0, 1) == 1)
                return read_item(7'($urandom_range(0, in_use - 1)));
            return read_item(7'($urandom));
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            sample = 16'($urandom);
        else if (pick < 40)
            sample = last_sample;
        else
            sample = aimed_sample();
        pick = $urandom_range(0, 9);
        weight = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
        last_sample = sample;
        return acc_item(sample, weight);
    endfunction

    // Each field is drawn from its extremes part of the time, including the
    // zero-cell and over-depth cell counts and a zero scale.
    task automatic random_setting();
        logic signed [15:0] lower_bound;
        logic [23:0]        cell_scale;
        logic [7:0]         num_cells;
        case ($urandom_range(0, 3))
            0:       lower_bound = 16'sh8000;
            1:       lower_bound = 16'sh7FFF;
            2:       lower_bound = 16'($urandom);
            default: lower_bound = 16'(int'($urandom_range(0, 2047)) - 1024);
        endcase
        case ($urandom_range(0, 7))
            0:       cell_scale = 24'd0;
            1:       cell_scale = 24'hFFFFFF;
            2:       cell_scale = 24'd65536;
            3, 4:    cell_scale = 24'($urandom_range(24'h001000, 24'h100000));
            default: cell_scale = 24'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       num_cells = 8'd0;
            1:       num_cells = 8'd1;
            2:       num_cells = 8'd128;
            3:       num_cells = 8'd255;
            default: num_cells = 8'($urandom_range(2, 127));
        endcase
        configure(lower_bound, cell_scale, num_cells, 1'($urandom), 1'($urandom));
    endtask

    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setting: the cell is the integer part of the sample, 100
        // cells, no clamping, each sample counts one whatever its weight.
        // The first push also waits out the store clear after reset.
        push_item(acc_item(16'h0000, 16'hFFFF));
        push_item(acc_item(16'h00FF, 16'h1234));
        push_item(acc_item(16'h63FF, 16'h0000));   // last cell in use
        push_item(acc_item(16'h6400, 16'h0001));   // first cell past the end
        push_item(acc_item(16'h7FFF, 16'hFFFF));   // most positive sample
        push_item(acc_item(16'h8000, 16'hFFFF));   // most negative sample
        push_item(acc_item(16'hFFFF, 16'h0001));   // just below zero floors to -1
        push_item(read_item(7'd0));
        push_item(read_item(7'd99));
        push_item(read_item(7'd127));
        wait_idle();

        // Left edge at the bottom, the finest scale, a cell count above the
        // store depth, clamping and weights all at once.
        configure(16'sh8000, 24'hFFFFFF, 8'd255, 1'b1, 1'b1);
        push_item(acc_item(16'h8000, 16'hFFFF));
        push_item(acc_item(16'h7FFF, 16'h0001));
        push_item(acc_item(16'h7FFF, 16'h0000));
        push_item(read_item(7'd0));
        push_item(read_item(7'd127));
        wait_idle();

        // A zero scale puts every sample into the first cell, even one far
        // below the left edge.
        configure(16'sh7FFF, 24'd0, 8'd1, 1'b0, 1'b1);
        push_item(acc_item(16'h8000, 16'h00AA));
        push_item(acc_item(16'h1234, 16'h0055));
        push_item(read_item(7'd0));
        wait_idle();

        // With no cells in use every sample is dropped, clamping or not.
        configure(16'sh0000, 24'd65536, 8'd0, 1'b1, 1'b0);
        push_item(acc_item(16'h0100, 16'h0001));
        push_item(acc_item(16'h8000, 16'hFFFF));
        push_item(read_item(7'd1));
        push_item(read_item(7'd0));
        wait_idle();

        // Random settings, each followed by a bursty random stream. One phase
        // opens with a long receiver hold-off while reads keep coming, so the
        // queue fills and the input stalls.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_setting();
            if (phase == RANDOM_PHASES / 2) begin
                hold_requests <= hold_requests + 1;
                for (k = 0; k < PRESSURE_READS; k++) push_item(read_item(7'($urandom)));
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) send_paced(random_item());
            wait_idle();
        end

        // Read back the whole store so that no total goes unchecked.
        for (k = 0; k < STORE_DEPTH; k++) send_paced(read_item(7'(k)));
        wait_idle();

        if (error_count == 0 && reads_pending == 0) begin
            $display("tb_weighted_histogram_binner: done, clean");
        end else begin
            $display("tb_weighted_histogram_binner: done, errors");
        end
        $finish;
    end

endmodule
